// ===== design/shx_pkg.sv =====
// Package with payload types, constants and status codes for the SH subset executor.
`default_nettype none
package shx_pkg;
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw = $clog2(MemWords);
  localparam logic [31:0] AddrMax = 32'(MemWords * 4 - 4);
  localparam logic [31:0] FloatOne = 32'h3F80_0000;

  typedef enum logic [2:0] {
    StOk = 3'd0, StHalt = 3'd1, StPcRange = 3'd2, StUnknown = 3'd3, StEof = 3'd4
  } status_e;

  typedef struct packed {
    logic        op;
    logic [9:0]  word_index;
    logic [31:0] word_data;
    logic [7:0]  in_byte;
    logic        in_eof;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        mem_fault;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [31:0] pc_after;
    logic        t_flag;
  } out_word_t;
endpackage
`default_nettype wire

// ===== design/sh_subset_instruction_executor_unit.sv =====
// Top level of the SH subset instruction executor.
// An execute word goes through fetch read, data read and write back; a preload word is written directly.
// Execute words do not overlap, because of the single memory port and the PC loop.
// A new word is accepted only in the idle state while the result register is empty or drains.
// Reset clears registers, PC, PR, FPUL, T and control; memory contents are undefined.
`default_nettype none
module sh_subset_instruction_executor_unit import shx_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);
  // Sequencer states.
  typedef enum logic [2:0] {
    SIdle = 3'b001, SFetch = 3'b010, SData = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mem [MemWords];
  logic [31:0] rdata_q;

  logic [31:0] gr_q [16];
  logic [31:0] fr_q [16];
  logic [31:0] pc_q, pr_q, fpul_q;
  logic        t_q;
  in_word_t    it_q;
  logic [15:0] ins_q;

  logic        ovld_q;
  out_word_t   obuf_q;

  // Memory port, driven by the sequencer.
  logic            mwe, mre;
  logic [MemAw-1:0] maddr;
  logic [31:0]     mwdata;
  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    if (mre) rdata_q <= mem[maddr];
  end

  // A word may enter only when the result slot is free or being drained.
  logic slot_free;
  assign slot_free = !ovld_q || !out_stall_i;
  assign in_stall_o = !(state_q == SIdle) || !slot_free;
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // Decode fields from the latched instruction.
  logic [3:0] opc, rn, rm, fn;
  logic [7:0] imm;
  logic [15:0] ins_w;
  assign ins_w = pc_q[1] ? rdata_q[31:16] : rdata_q[15:0];
  always_comb begin
    opc = ins_q[15:12]; rn = ins_q[11:8]; rm = ins_q[7:4]; fn = ins_q[3:0];
    imm = ins_q[7:0];
  end
  logic [31:0] rnv, rmv, fnv, fmv, simm;
  assign rnv = gr_q[rn];
  assign rmv = gr_q[rm];
  assign fnv = fr_q[rn];
  assign fmv = fr_q[rm];
  assign simm = {{24{imm[7]}}, imm};

  // Data access classification.
  logic is_ld, is_st, is_fld;
  logic [31:0] daddr, sdata;
  always_comb begin
    is_ld = 1'b0; is_st = 1'b0; is_fld = 1'b0; daddr = rmv; sdata = rmv;
    case (opc)
      4'h9: begin is_ld = 1'b1; daddr = {22'd0, imm, 2'b00} + (pc_q & 32'hFFFF_FFFC) + 32'd4; end
      4'h6: if (fn == 4'h2) is_ld = 1'b1;
      4'h2: if (fn == 4'h2) begin is_st = 1'b1; daddr = rnv; sdata = rmv; end
      4'hF: begin
        if (fn == 4'h8) is_fld = 1'b1;
        if (fn == 4'hA) begin is_st = 1'b1; daddr = rnv; sdata = fmv; end
      end
      default: ;
    endcase
  end
  logic dok;
  assign dok = daddr <= AddrMax;

  function automatic logic f_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction
  function automatic logic [31:0] f_key(input logic [31:0] x);
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  // Execute: compute register updates and result.
  logic        gw, fw, prw, fpw, tw, tv, ok, halt, eof, ov;
  logic [31:0] gv, fv, prv, fpv, nxt;
  logic [7:0]  ob;
  logic [31:0] dval;
  logic [4:0]  sh;
  logic [11:0] d12;
  logic [31:0] bd;
  always_comb begin
    gw = 1'b0; fw = 1'b0; prw = 1'b0; fpw = 1'b0; tw = 1'b0; tv = 1'b0;
    ok = 1'b1; halt = 1'b0; eof = 1'b0; ov = 1'b0; ob = 8'd0;
    gv = 32'd0; fv = 32'd0; prv = 32'd0; fpv = 32'd0;
    nxt = pc_q + 32'd2;
    dval = rdata_q;
    sh = rmv[4:0];
    d12 = ins_q[11:0];
    bd = {{19{d12[11]}}, d12, 1'b0} + 32'd4;
    case (opc)
      4'h7: begin gw = 1'b1; gv = rnv + simm; end
      4'hE: begin gw = 1'b1; gv = simm; end
      4'h8: begin
        if (rn == 4'h9 || rn == 4'hB) begin
          if ((rn == 4'h9) == t_q) nxt = pc_q + {simm[30:0], 1'b0} + 32'd4;
        end else ok = 1'b0;
      end
      4'h9: begin gw = dok; gv = dval; end
      4'hA: begin
        if (bd == 32'd0) begin halt = 1'b1; nxt = pc_q; end
        else nxt = pc_q + bd;
      end
      4'h0: begin
        if (fn == 4'h0) begin ov = 1'b1; ob = rnv[7:0]; end
        else if (fn == 4'h1) begin
          if (it_q.in_eof) begin eof = 1'b1; nxt = pc_q; end
          else begin gw = 1'b1; gv = {24'd0, it_q.in_byte}; end
        end else if (fn == 4'hA && rm == 4'h2) begin gw = 1'b1; gv = pr_q; end
        else if (fn == 4'hA && rm == 4'h5) begin gw = 1'b1; gv = fpul_q; end
        else if (fn == 4'hB) nxt = pr_q;
        else ok = 1'b0;
      end
      4'h2: begin
        if (fn == 4'h2) ;
        else if (fn == 4'h9) begin gw = 1'b1; gv = rnv & rmv; end
        else if (fn == 4'hA) begin gw = 1'b1; gv = rnv ^ rmv; end
        else if (fn == 4'hB) begin gw = 1'b1; gv = rnv | rmv; end
        else ok = 1'b0;
      end
      4'h3: begin
        if (fn == 4'h0) begin tw = 1'b1; tv = rnv == rmv; end
        else if (fn == 4'h7) begin tw = 1'b1; tv = $signed(rnv) > $signed(rmv); end
        else if (fn == 4'h8) begin gw = 1'b1; gv = rnv - rmv; end
        else if (fn == 4'hC) begin gw = 1'b1; gv = rnv + rmv; end
        else ok = 1'b0;
      end
      4'h4: begin
        if (fn == 4'hA && rm == 4'h5) begin fpw = 1'b1; fpv = rnv; end
        else if (fn == 4'hB && rm == 4'h0) begin
          prw = 1'b1; prv = pc_q + 32'd4; nxt = rnv;
        end else if (fn == 4'hB && rm == 4'h2) nxt = rnv;
        else if (fn == 4'hD) begin
          gw = 1'b1;
          if (!rmv[31]) gv = rnv << sh;
          else if (sh == 5'd0) gv = 32'd0;
          else gv = rnv >> ({1'b0, ~sh} + 6'd1);
        end else ok = 1'b0;
      end
      4'h6: begin
        if (fn == 4'h2) begin gw = dok; gv = dval; end
        else if (fn == 4'h3) begin gw = 1'b1; gv = rmv; end
        else if (fn == 4'h7) begin gw = 1'b1; gv = ~rmv; end
        else ok = 1'b0;
      end
      4'hF: begin
        if (fn == 4'h4) begin
          tw = 1'b1;
          tv = !f_nan(fnv) && !f_nan(fmv) &&
               (((fnv[30:0] == 31'd0) && (fmv[30:0] == 31'd0)) || fnv == fmv);
        end else if (fn == 4'h5) begin
          tw = 1'b1;
          tv = !f_nan(fnv) && !f_nan(fmv) &&
               !((fnv[30:0] == 31'd0) && (fmv[30:0] == 31'd0)) &&
               (f_key(fnv) > f_key(fmv));
        end else if (fn == 4'h8) begin fw = dok; fv = dval; end
        else if (fn == 4'hA) ;
        else if (fn == 4'hC) begin fw = 1'b1; fv = fmv; end
        else if (fn == 4'hD && rm == 4'h0) begin fw = 1'b1; fv = fpul_q; end
        else if (fn == 4'hD && rm == 4'h1) begin fpw = 1'b1; fpv = fnv; end
        else if (fn == 4'hD && rm == 4'h8) begin fw = 1'b1; fv = 32'd0; end
        else if (fn == 4'hD && rm == 4'h9) begin fw = 1'b1; fv = FloatOne; end
        else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    if (!ok || eof) begin
      gw = 1'b0; fw = 1'b0; prw = 1'b0; fpw = 1'b0; tw = 1'b0; ov = 1'b0; ob = 8'd0;
    end
  end

  logic fault;
  assign fault = ok && (is_ld || is_st || is_fld) && !dok;

  // Fetch state: latch the instruction and read its data word on the same port.
  logic [15:0]     ins_d;
  logic [31:0]     ld_addr;
  always_comb begin
    ins_d = ins_w;
    ld_addr = (ins_w[15:12] == 4'h9)
      ? ({22'd0, ins_w[7:0], 2'b00} + (pc_q & 32'hFFFF_FFFC) + 32'd4)
      : gr_q[ins_w[7:4]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SFetch) ins_q <= ins_d;
  end

  // Sequencer: next state and memory port control (enables, address, write data).
  always_comb begin
    state_d = state_q;
    mwe = 1'b0; mre = 1'b0; maddr = pc_q[MemAw+1:2]; mwdata = it_q.word_data;
    case (state_q)
      SIdle: if (acc && !in_data_i.op && (pc_q <= AddrMax)) begin
        mre = 1'b1; state_d = SFetch;
      end else if (acc && in_data_i.op) begin
        mwe = 32'(in_data_i.word_index) < MemWords;
        maddr = MemAw'(in_data_i.word_index);
        mwdata = in_data_i.word_data;
      end
      SFetch: begin
        state_d = SData;
        mre = 1'b1;
        maddr = ld_addr[MemAw+1:2];
      end
      SData: begin
        state_d = SIdle;
        if (is_st && dok) begin mwe = 1'b1; maddr = daddr[MemAw+1:2]; mwdata = sdata; end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pc_q <= '0; pr_q <= '0; fpul_q <= '0; t_q <= 1'b0;
      ovld_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin gr_q[i] <= '0; fr_q[i] <= '0; end
    end else begin
      state_q <= state_d;
      if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      if (acc) it_q <= in_data_i;
      if (acc && (in_data_i.op || (pc_q > AddrMax))) begin
        ovld_q <= 1'b1;
        obuf_q <= '{status: in_data_i.op ? StOk : StPcRange, mem_fault: 1'b0,
                    out_valid: 1'b0, out_byte: 8'd0, pc_after: pc_q, t_flag: t_q};
      end
      if (state_q == SData) begin
        if (gw) gr_q[rn] <= gv;
        if (fw) fr_q[rn] <= fv;
        if (prw) pr_q <= prv;
        if (fpw) fpul_q <= fpv;
        if (tw) t_q <= tv;
        if (ok) pc_q <= nxt;
        ovld_q <= 1'b1;
        obuf_q <= '{status: !ok ? StUnknown : eof ? StEof : halt ? StHalt : StOk,
                    mem_fault: fault, out_valid: ov, out_byte: ob,
                    pc_after: ok ? nxt : pc_q, t_flag: tw ? tv : t_q};
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o = obuf_q;
endmodule
`default_nettype wire
